// ----- src/msrd_pkg.sv -----
package msrd_pkg;

  localparam int SPEED_W   = 8;
  localparam int DIR_W     = 2;
  localparam int MODE_W    = 2;
  localparam int ELAPSED_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [DIR_W-1:0] DIR_STOP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD     = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV     = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UNUSED  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_STEADY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACCEL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DECEL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FLIP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCELERATION = 2'd1;

  localparam logic [CFG_W-1:0] HYSTERESIS_RST   = 8'd8;
  localparam logic [CFG_W-1:0] ACCELERATION_RST = 8'd6;

  typedef struct packed {
    logic                 action;
    logic [DIR_W-1:0]     command_direction;
    logic [SPEED_W-1:0]   command_speed;
    logic [ELAPSED_W-1:0] elapsed;
  } in_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] duty;
    logic               drive_forward;
    logic               drive_reverse;
    logic [MODE_W-1:0]  ramp_mode;
  } out_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] present_speed;
    logic [SPEED_W-1:0] goal_speed;
    logic [SPEED_W-1:0] pending_speed;
    logic [DIR_W-1:0]   pending_direction;
    logic [DIR_W-1:0]   present_direction;
    logic [MODE_W-1:0]  mode;
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] hysteresis;
    logic [CFG_W-1:0] acceleration;
  } cfg_t;

endpackage

// ----- src/msrd_core.sv -----
module msrd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  msrd_pkg::in_word_t  word,
  input  msrd_pkg::cfg_t      cfg,
  output msrd_pkg::out_word_t res
);

  msrd_pkg::state_t st_r;
  msrd_pkg::state_t st_nxt;
  msrd_pkg::state_t c;

  logic [23:0]                   prod;
  logic [msrd_pkg::SPEED_W-1:0]  step;
  logic [msrd_pkg::DIR_W-1:0]    dir_c;
  logic [msrd_pkg::SPEED_W:0]    sum;
  logic [msrd_pkg::SPEED_W:0]    dec_lim;

  assign prod = word.elapsed * cfg.acceleration;
  // saturate the ramp step at full scale
  assign step = (|prod[23:8]) ? 8'hFF : prod[7:0];
  assign dir_c = (word.command_direction == msrd_pkg::DIR_UNUSED) ?
                 msrd_pkg::DIR_STOP : word.command_direction;

  // command phase
  always_comb begin
    c = st_r;
    if (word.action) begin
      if (st_r.present_direction == dir_c) begin
        if (dir_c == msrd_pkg::DIR_STOP) begin
          c.present_speed = '0;
          c.goal_speed    = '0;
          c.mode          = msrd_pkg::MODE_STEADY;
        end else if ({1'b0, st_r.present_speed} >=
                     ({1'b0, word.command_speed} + {1'b0, cfg.hysteresis})) begin
          c.goal_speed = word.command_speed;
          c.mode       = msrd_pkg::MODE_DECEL;
        end else if (({1'b0, st_r.present_speed} + {1'b0, cfg.hysteresis}) <=
                     {1'b0, word.command_speed}) begin
          c.goal_speed = word.command_speed;
          c.mode       = msrd_pkg::MODE_ACCEL;
        end else begin
          // inside the band: snap
          c.present_speed = word.command_speed;
          c.goal_speed    = word.command_speed;
          c.mode          = msrd_pkg::MODE_STEADY;
        end
      end else if (st_r.present_direction == msrd_pkg::DIR_STOP) begin
        c.present_speed     = '0;
        c.goal_speed        = word.command_speed;
        c.mode              = msrd_pkg::MODE_ACCEL;
        c.present_direction = dir_c;
      end else if (dir_c == msrd_pkg::DIR_STOP) begin
        c.goal_speed = '0;
        c.mode       = msrd_pkg::MODE_DECEL;
      end else begin
        c.pending_speed     = word.command_speed;
        c.pending_direction = dir_c;
        c.mode              = msrd_pkg::MODE_FLIP;
      end
    end
  end

  assign sum     = {1'b0, c.present_speed} + {1'b0, step};
  assign dec_lim = {1'b0, c.goal_speed} + {1'b0, step};

  // ramp phase
  always_comb begin
    st_nxt = c;
    case (c.mode)
      msrd_pkg::MODE_ACCEL: begin
        if (sum >= {1'b0, c.goal_speed}) begin
          st_nxt.present_speed = c.goal_speed;
          st_nxt.mode          = msrd_pkg::MODE_STEADY;
        end else begin
          st_nxt.present_speed = sum[msrd_pkg::SPEED_W-1:0];
        end
      end
      msrd_pkg::MODE_DECEL: begin
        if ({1'b0, c.present_speed} <= dec_lim) begin
          st_nxt.present_speed = c.goal_speed;
          st_nxt.mode          = msrd_pkg::MODE_STEADY;
          if (c.goal_speed == '0) begin
            st_nxt.present_direction = msrd_pkg::DIR_STOP;
          end
        end else begin
          st_nxt.present_speed = c.present_speed - step;
        end
      end
      msrd_pkg::MODE_FLIP: begin
        if (c.present_speed <= step) begin
          // reached zero: take the pending command
          st_nxt.present_speed     = '0;
          st_nxt.present_direction = c.pending_direction;
          st_nxt.goal_speed        = c.pending_speed;
          st_nxt.mode              = msrd_pkg::MODE_ACCEL;
        end else begin
          st_nxt.present_speed = c.present_speed - step;
        end
      end
      default: begin
        st_nxt = c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign res.duty          = st_nxt.present_speed;
  assign res.drive_forward = (st_nxt.present_direction == msrd_pkg::DIR_FWD);
  assign res.drive_reverse = (st_nxt.present_direction == msrd_pkg::DIR_REV);
  assign res.ramp_mode     = st_nxt.mode;

endmodule

// ----- src/motor_speed_ramp_direction_control.sv -----
// A word is held in the input register, and its result in the result register.
// Throughput: one word per cycle unless out_stall holds the output; the speed and
// direction update is a single pass through the command and ramp logic between them.
// Reset (rst_n low at a clock edge): both registers empty, speeds zero,
// direction stop, mode steady, hysteresis 8, acceleration 6.
module motor_speed_ramp_direction_control (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  msrd_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output msrd_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msrd_pkg::CFG_W-1:0]          cfg_data
);

  logic                 a_valid_r;
  logic                 a_valid_nxt;
  msrd_pkg::in_word_t   a_word_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  msrd_pkg::out_word_t  out_word_r;
  msrd_pkg::out_word_t  res;
  msrd_pkg::cfg_t       cfg_r;
  logic                 adv;
  logic                 in_acc;

  assign cfg_ready = 1'b1;
  assign adv       = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = a_valid_r && out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
    end else if (adv) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r          <= 1'b0;
      out_valid_r        <= 1'b0;
      cfg_r.hysteresis   <= msrd_pkg::HYSTERESIS_RST;
      cfg_r.acceleration <= msrd_pkg::ACCELERATION_RST;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          msrd_pkg::REG_HYSTERESIS:   cfg_r.hysteresis   <= cfg_data;
          msrd_pkg::REG_ACCELERATION: cfg_r.acceleration <= cfg_data;
          default: begin
            // drop writes to unknown registers
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_word_r <= in_word;
    end
    if (adv) begin
      out_word_r <= res;
    end
  end

  msrd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .word  (a_word_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && out_valid_r))
    else $error("input stalled without a held word");

  a_word_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("processed word not presented at output");

  a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.drive_forward && out_word.drive_reverse))
    else $error("both drive directions active");

  a_stop_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.drive_forward && !out_word.drive_reverse) |->
      (out_word.duty == '0 && out_word.ramp_mode == msrd_pkg::MODE_STEADY))
    else $error("stopped motor with nonzero duty or active ramp");

endmodule

// ----- test/motor_speed_ramp_direction_control_tb.sv -----
module motor_speed_ramp_direction_control_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int RANDOM_PHASES = 11;

  typedef logic [msrd_pkg::SPEED_W-1:0]   speed_t;
  typedef logic [msrd_pkg::DIR_W-1:0]     dir_t;
  typedef logic [msrd_pkg::MODE_W-1:0]    mode_t;
  typedef logic [msrd_pkg::ELAPSED_W-1:0] elapsed_t;
  typedef logic [msrd_pkg::CFG_W-1:0]     reg_val_t;
  typedef logic [msrd_pkg::CFG_IDX_W-1:0] reg_idx_t;

  class ramp_scoreboard;
    msrd_pkg::out_word_t drive_words_due[$];
    reg_val_t hyst;
    reg_val_t accel_rate;
    speed_t speed;
    speed_t goal;
    speed_t pend_speed;
    dir_t pend_dir;
    dir_t dir;
    mode_t mode;
    int errors;

    function new();
      hyst = msrd_pkg::HYSTERESIS_RST;
      accel_rate = msrd_pkg::ACCELERATION_RST;
      speed = '0;
      goal = '0;
      pend_speed = '0;
      pend_dir = msrd_pkg::DIR_STOP;
      dir = msrd_pkg::DIR_STOP;
      mode = msrd_pkg::MODE_STEADY;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, reg_val_t val);
      if (idx == msrd_pkg::REG_HYSTERESIS) hyst = val;
      else if (idx == msrd_pkg::REG_ACCELERATION) accel_rate = val;
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v >= hi) return hi;
      if (v <= lo) return lo;
      return v;
    endfunction

    // Apply the command, let the ticks pass, queue the resulting drive word.
    function void note_command_word(msrd_pkg::in_word_t w);
      dir_t cdir;
      int ps;
      int cs;
      int h;
      int step;
      msrd_pkg::out_word_t due;
      cdir = (w.command_direction == msrd_pkg::DIR_UNUSED) ?
             msrd_pkg::DIR_STOP : w.command_direction;
      if (w.action) begin
        if (dir == cdir) begin
          if (cdir == msrd_pkg::DIR_STOP) begin
            speed = '0;
            goal = '0;
            mode = msrd_pkg::MODE_STEADY;
          end else begin
            ps = int'(speed);
            cs = int'(w.command_speed);
            h = int'(hyst);
            if (ps >= cs + h) begin
              goal = w.command_speed;
              mode = msrd_pkg::MODE_DECEL;
            end else if (ps <= cs - h) begin
              goal = w.command_speed;
              mode = msrd_pkg::MODE_ACCEL;
            end else begin
              speed = w.command_speed;
              goal = w.command_speed;
              mode = msrd_pkg::MODE_STEADY;
            end
          end
        end else if (dir == msrd_pkg::DIR_STOP) begin
          speed = '0;
          goal = w.command_speed;
          mode = msrd_pkg::MODE_ACCEL;
          dir = cdir;
        end else if (cdir == msrd_pkg::DIR_STOP) begin
          goal = '0;
          mode = msrd_pkg::MODE_DECEL;
        end else begin
          pend_speed = w.command_speed;
          pend_dir = cdir;
          mode = msrd_pkg::MODE_FLIP;
        end
      end

      step = int'(accel_rate) * int'(w.elapsed);
      if (step > 255) step = 255;
      ps = int'(speed);
      case (mode)
        msrd_pkg::MODE_ACCEL: begin
          speed = speed_t'(clamp(ps + step, 0, int'(goal)));
          if (speed == goal) mode = msrd_pkg::MODE_STEADY;
        end
        msrd_pkg::MODE_DECEL: begin
          speed = speed_t'(clamp(ps - step, int'(goal), 255));
          if (speed == goal) begin
            mode = msrd_pkg::MODE_STEADY;
            if (speed == 0) dir = msrd_pkg::DIR_STOP;
          end
        end
        msrd_pkg::MODE_FLIP: begin
          speed = speed_t'(clamp(ps - step, 0, 255));
          if (speed == 0) begin
            dir = pend_dir;
            goal = pend_speed;
            mode = msrd_pkg::MODE_ACCEL;
          end
        end
        default: ;
      endcase

      due.duty = speed;
      due.drive_forward = (dir == msrd_pkg::DIR_FWD);
      due.drive_reverse = (dir == msrd_pkg::DIR_REV);
      due.ramp_mode = mode;
      drive_words_due.push_back(due);
    endfunction

    function void check_drive_word(msrd_pkg::out_word_t got);
      msrd_pkg::out_word_t due;
      if (drive_words_due.size() == 0) begin
        $display("%0t: unexpected drive word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      due = drive_words_due.pop_front();
      if (got.duty !== due.duty) begin
        $display("%0t: duty expected %0d actual %0d", $time, due.duty, got.duty);
        errors++;
      end
      if (got.drive_forward !== due.drive_forward) begin
        $display("%0t: drive_forward expected %b actual %b", $time,
                 due.drive_forward, got.drive_forward);
        errors++;
      end
      if (got.drive_reverse !== due.drive_reverse) begin
        $display("%0t: drive_reverse expected %b actual %b", $time,
                 due.drive_reverse, got.drive_reverse);
        errors++;
      end
      if (got.ramp_mode !== due.ramp_mode) begin
        $display("%0t: ramp_mode expected %0d actual %0d", $time,
                 due.ramp_mode, got.ramp_mode);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  msrd_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  msrd_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_index = '0;
  reg_val_t cfg_data = '0;

  ramp_scoreboard sb;
  int idle_odds = 0;
  int stall_odds = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  motor_speed_ramp_direction_control u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_command_word(in_word);
    if (rst_n && out_valid && !out_stall) sb.check_drive_word(out_word);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: a long hold-off on request, otherwise random stall bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (stall_odds > 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic msrd_pkg::in_word_t make_word(logic act, dir_t d, speed_t s,
                                                   elapsed_t e);
    msrd_pkg::in_word_t w;
    w.action = act;
    w.command_direction = d;
    w.command_speed = s;
    w.elapsed = e;
    return w;
  endfunction

  function automatic msrd_pkg::in_word_t random_word();
    msrd_pkg::in_word_t w;
    int r;
    int v;
    int jitter;
    w.action = ($urandom_range(0, 9) < 4);
    r = $urandom_range(0, 9);
    w.command_direction = (r < 4) ? msrd_pkg::DIR_FWD : (r < 8) ? msrd_pkg::DIR_REV :
                          (r < 9) ? msrd_pkg::DIR_STOP : msrd_pkg::DIR_UNUSED;
    if ($urandom_range(0, 2) == 0) begin
      // aim at the edges of the hysteresis band around the present speed
      jitter = $urandom_range(0, 2);
      v = int'(sb.speed) + (($urandom_range(0, 1) == 1) ? int'(sb.hyst) : -int'(sb.hyst))
          + jitter - 1;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      w.command_speed = speed_t'(v);
    end else begin
      w.command_speed = speed_t'($urandom_range(0, 255));
    end
    r = $urandom_range(0, 9);
    if (r < 6) w.elapsed = elapsed_t'($urandom_range(0, 4));
    else if (r < 8) w.elapsed = elapsed_t'($urandom_range(0, 300));
    else if (r < 9) w.elapsed = elapsed_t'($urandom_range(0, 65535));
    else if (sb.accel_rate != 0)
      w.elapsed = elapsed_t'(255 / int'(sb.accel_rate) + int'($urandom_range(0, 1)));
    else w.elapsed = 16'hFFFF;
    return w;
  endfunction

  task automatic send_word(input msrd_pkg::in_word_t w);
    if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_cmd(input logic act, input dir_t d, input speed_t s,
                          input elapsed_t e);
    send_word(make_word(act, d, s, e));
  endtask

  // Drop valid and hold until every drive word due has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.drive_words_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input reg_val_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    reg_val_t h;
    reg_val_t a;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    idle_odds = 5;
    stall_odds = 6;
    // unknown register indexes must leave both settings alone
    write_reg(2'd2, 8'hFF);
    write_reg(2'd3, 8'h00);

    send_cmd(1'b0, msrd_pkg::DIR_STOP, 8'd0, 16'd0);
    send_cmd(1'b1, msrd_pkg::DIR_FWD, 8'd200, 16'd1);
    send_cmd(1'b0, msrd_pkg::DIR_STOP, 8'd0, 16'hFFFF);
    send_cmd(1'b1, msrd_pkg::DIR_FWD, 8'd205, 16'd0);
    send_cmd(1'b1, msrd_pkg::DIR_FWD, 8'd100, 16'd2);
    send_cmd(1'b1, msrd_pkg::DIR_REV, 8'd255, 16'd3);
    send_cmd(1'b0, msrd_pkg::DIR_STOP, 8'd0, 16'hFFFF);
    send_cmd(1'b0, msrd_pkg::DIR_STOP, 8'd0, 16'd100);
    send_cmd(1'b1, msrd_pkg::DIR_UNUSED, 8'd77, 16'd10);
    send_cmd(1'b0, msrd_pkg::DIR_STOP, 8'd0, 16'hFFFF);
    send_cmd(1'b1, msrd_pkg::DIR_FWD, 8'd0, 16'd5);
    send_cmd(1'b1, msrd_pkg::DIR_REV, 8'd0, 16'd1);
    send_cmd(1'b0, msrd_pkg::DIR_UNUSED, 8'd255, 16'd0);
    send_cmd(1'b1, msrd_pkg::DIR_STOP, 8'd255, 16'd0);
    send_cmd(1'b1, msrd_pkg::DIR_STOP, 8'd0, 16'd0);
    drain();

    // zero acceleration stalls every ramp
    write_reg(msrd_pkg::REG_ACCELERATION, 8'd0);
    write_reg(msrd_pkg::REG_HYSTERESIS, 8'd0);
    send_cmd(1'b1, msrd_pkg::DIR_FWD, 8'd50, 16'hFFFF);
    send_cmd(1'b0, msrd_pkg::DIR_STOP, 8'd0, 16'd1000);
    send_cmd(1'b1, msrd_pkg::DIR_FWD, 8'd50, 16'd7);
    drain();

    write_reg(msrd_pkg::REG_HYSTERESIS, 8'd255);
    write_reg(msrd_pkg::REG_ACCELERATION, 8'd255);
    send_cmd(1'b1, msrd_pkg::DIR_FWD, 8'd10, 16'd0);
    send_cmd(1'b1, msrd_pkg::DIR_FWD, 8'd255, 16'd1);
    send_cmd(1'b1, msrd_pkg::DIR_REV, 8'd128, 16'd1);
    send_cmd(1'b0, msrd_pkg::DIR_STOP, 8'd0, 16'd1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin h = 8'd0; a = 8'd1; end
        1: begin h = 8'd255; a = 8'd255; end
        2: begin h = msrd_pkg::HYSTERESIS_RST; a = msrd_pkg::ACCELERATION_RST; end
        default: begin
          h = reg_val_t'($urandom_range(0, 255));
          a = reg_val_t'($urandom_range(1, 255));
        end
      endcase
      write_reg(msrd_pkg::REG_HYSTERESIS, h);
      write_reg(msrd_pkg::REG_ACCELERATION, a);
      if (p >= RANDOM_PHASES - 2 || p == 4 || p == 3) begin
        idle_odds = 0;
        stall_odds = 0;
      end else begin
        idle_odds = $urandom_range(2, 8);
        stall_odds = $urandom_range(2, 8);
      end
      // keep offering words while the receiver holds off, so the block backs up
      if (p == 3) hold_cycles = 200;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_word(random_word());
      drain();
    end

    if (sb.errors == 0 && sb.drive_words_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
